[rtl/i2cram_pkg.sv]
// Shared types and constants for the I2C register access master.
// Used by the front queue, the bus engine, the result queue and the top level.
package i2cram_pkg;

	localparam int unsigned TICK_COUNT_BITS_DEF = 16;

	// decoupling queue depth, both sides
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [1:0] REG_DEV_ADDR = 2'd0;
	localparam logic [1:0] REG_QTR_BIT  = 2'd1;
	localparam logic [1:0] REG_ACK_WAIT = 2'd2;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_WR_ADR_NACK = 2'd1;
	localparam logic [1:0] ST_WR_DAT_NACK = 2'd2;
	localparam logic [1:0] ST_RD_NACK     = 2'd3;

	localparam logic [6:0]  DEV_ADDR_RST = 7'd39;
	localparam logic [15:0] QTR_BIT_RST  = 16'd250;
	localparam logic [15:0] ACK_WAIT_RST = 16'd400;

	typedef struct packed {
		logic       start_wr;
		logic       start_rd;
		logic [7:0] reg_sel;
		logic [7:0] wdata;
		logic       sda;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_pull;
		logic       busy;
		logic       done;
		logic [1:0] status;
		logic [7:0] rdata;
	} result_t;

endpackage

[rtl/i2cram_front.sv]
// Front end: classifies incoming tick beats and queues them for the bus engine.
// Depends on i2cram_pkg.
module i2cram_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           action,
	input  logic [7:0]           sub_address,
	input  logic [7:0]           write_data,
	input  logic                 sda_in,
	input  logic                 deq,
	output logic                 item_valid,
	output i2cram_pkg::item_t    item
);
	import i2cram_pkg::*;

	item_t                mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 wr_en;
	logic                 rd_en;
	item_t                cls;

	assign full       = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign wr_en      = push && !full;
	assign rd_en      = deq && item_valid;

	always_comb begin
		cls.start_wr = (action == ACT_WRITE);
		cls.start_rd = (action == ACT_READ);
		cls.reg_sel  = sub_address;
		cls.wdata    = write_data;
		cls.sda      = sda_in;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	assign item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/i2cram_engine.sv]
// Bus engine: I2C phase sequencer and config registers, one queued beat per step.
// Depends on i2cram_pkg; fed by i2cram_front, drains into i2cram_resq.
module i2cram_engine #(
	parameter int unsigned TickBits = i2cram_pkg::TICK_COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_wdata,
	input  logic                 item_valid,
	input  i2cram_pkg::item_t    item,
	output logic                 deq,
	input  logic                 res_full,
	output logic                 res_push,
	output i2cram_pkg::result_t  res
);
	import i2cram_pkg::*;

	localparam logic [4:0] PH_IDLE      = 5'd0;
	localparam logic [4:0] PH_START_A   = 5'd1;
	localparam logic [4:0] PH_START_B   = 5'd2;
	localparam logic [4:0] PH_START_C   = 5'd3;
	localparam logic [4:0] PH_TX_LOW    = 5'd4;
	localparam logic [4:0] PH_TX_HIGH   = 5'd5;
	localparam logic [4:0] PH_ACK_LOW   = 5'd6;
	localparam logic [4:0] PH_ACK_WAIT  = 5'd7;
	localparam logic [4:0] PH_ACK_HOLD  = 5'd8;
	localparam logic [4:0] PH_RS_A      = 5'd9;
	localparam logic [4:0] PH_RS_B      = 5'd10;
	localparam logic [4:0] PH_RX_LOW    = 5'd11;
	localparam logic [4:0] PH_RX_HIGH   = 5'd12;
	localparam logic [4:0] PH_NACK_LOW  = 5'd13;
	localparam logic [4:0] PH_NACK_HIGH = 5'd14;
	localparam logic [4:0] PH_STOP_A    = 5'd15;
	localparam logic [4:0] PH_STOP_B    = 5'd16;
	localparam logic [4:0] PH_STOP_C    = 5'd17;

	localparam logic [1:0] BS_ADDR = 2'd0;
	localparam logic [1:0] BS_SUB  = 2'd1;
	localparam logic [1:0] BS_DATA = 2'd2;
	localparam logic [1:0] BS_READ = 2'd3;

	localparam int unsigned LimW = (TickBits > 16) ? TickBits : 16;

	logic [6:0]          dev_q;
	logic [15:0]         qtr_q;
	logic [15:0]         ack_lim_q;

	logic [4:0]          phase_q, ph_n;
	logic [3:0]          bc_q, bc_n;
	logic [7:0]          sb_q, sb_n;
	logic [TickBits-1:0] tc_q, tc_n;
	logic [15:0]         aw_q, aw_n;
	logic                rd_q, rd_n;
	logic [7:0]          sub_q, sub_n;
	logic [7:0]          wd_q, wd_n;
	logic [1:0]          st_q, st_n;
	logic [7:0]          rx_q, rx_n;
	logic [1:0]          bs_q, bs_n;
	logic                done_n;

	logic [15:0]         qtr_m1;
	logic [LimW-1:0]     lim_w;
	logic [TickBits-1:0] phase_lim;
	logic                step_en;

	assign step_en  = item_valid && !res_full;
	assign deq      = step_en;
	assign res_push = step_en;

	assign qtr_m1    = (qtr_q == '0) ? '0 : qtr_q - 16'd1;
	assign lim_w     = LimW'(qtr_m1);
	assign phase_lim = (lim_w > LimW'({TickBits{1'b1}})) ? '1 : lim_w[TickBits-1:0];

	always_comb begin
		ph_n   = phase_q;
		bc_n   = bc_q;
		sb_n   = sb_q;
		tc_n   = tc_q;
		aw_n   = aw_q;
		rd_n   = rd_q;
		sub_n  = sub_q;
		wd_n   = wd_q;
		st_n   = st_q;
		rx_n   = rx_q;
		bs_n   = bs_q;
		done_n = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.start_wr || item.start_rd) begin
				rd_n  = item.start_rd;
				sub_n = item.reg_sel;
				wd_n  = item.wdata;
				bs_n  = BS_ADDR;
				bc_n  = '0;
				aw_n  = '0;
				ph_n  = PH_START_A;
				tc_n  = '0;
			end
		end else if (phase_q == PH_ACK_WAIT) begin
			if (!item.sda) begin
				ph_n = PH_ACK_HOLD;
				tc_n = '0;
			end else begin
				aw_n = aw_q + 16'd1;
				if (aw_n >= ack_lim_q) begin
					if (rd_q) begin
						st_n = ST_RD_NACK;
					end else begin
						st_n = (bs_q == BS_DATA) ? ST_WR_DAT_NACK : ST_WR_ADR_NACK;
					end
					ph_n = PH_STOP_A;
					tc_n = '0;
				end
			end
		end else if (tc_q < phase_lim) begin
			tc_n = tc_q + TickBits'(1);
		end else begin
			tc_n = '0;
			unique case (phase_q)
				PH_START_A: ph_n = PH_START_B;
				PH_START_B: ph_n = PH_START_C;
				PH_START_C: begin
					sb_n = {dev_q, (bs_q == BS_READ)};
					bc_n = '0;
					ph_n = PH_TX_LOW;
				end
				PH_TX_LOW: ph_n = PH_TX_HIGH;
				PH_TX_HIGH: begin
					sb_n = {sb_q[6:0], 1'b0};
					bc_n = bc_q + 4'd1;
					ph_n = (bc_n >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
				end
				PH_ACK_LOW: begin
					aw_n = '0;
					ph_n = PH_ACK_WAIT;
				end
				PH_ACK_HOLD: begin
					unique case (bs_q)
						BS_ADDR: begin
							bs_n = BS_SUB;
							sb_n = sub_q;
							bc_n = '0;
							ph_n = PH_TX_LOW;
						end
						BS_SUB: begin
							if (rd_q) begin
								bs_n = BS_READ;
								ph_n = PH_RS_A;
							end else begin
								bs_n = BS_DATA;
								sb_n = wd_q;
								bc_n = '0;
								ph_n = PH_TX_LOW;
							end
						end
						BS_DATA: begin
							st_n = ST_OK;
							ph_n = PH_STOP_A;
						end
						default: begin
							sb_n = '0;
							bc_n = '0;
							ph_n = PH_RX_LOW;
						end
					endcase
				end
				PH_RS_A: ph_n = PH_RS_B;
				PH_RS_B: ph_n = PH_START_B;
				PH_RX_LOW: ph_n = PH_RX_HIGH;
				PH_RX_HIGH: begin
					sb_n = {sb_q[6:0], item.sda};
					bc_n = bc_q + 4'd1;
					if (bc_n >= 4'd8) begin
						rx_n = sb_n;
						st_n = ST_OK;
						ph_n = PH_NACK_LOW;
					end else begin
						ph_n = PH_RX_LOW;
					end
				end
				PH_NACK_LOW: ph_n = PH_NACK_HIGH;
				PH_NACK_HIGH: ph_n = PH_STOP_A;
				PH_STOP_A: ph_n = PH_STOP_B;
				PH_STOP_B: ph_n = PH_STOP_C;
				default: begin
					ph_n   = PH_IDLE;
					done_n = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		res.scl = !(ph_n == PH_START_C || ph_n == PH_TX_LOW || ph_n == PH_ACK_LOW
			|| ph_n == PH_RS_A || ph_n == PH_RX_LOW || ph_n == PH_NACK_LOW
			|| ph_n == PH_STOP_A);
		if (ph_n == PH_START_B || ph_n == PH_START_C || ph_n == PH_STOP_A
			|| ph_n == PH_STOP_B) begin
			res.sda_pull = 1'b1;
		end else if (ph_n == PH_TX_LOW || ph_n == PH_TX_HIGH) begin
			res.sda_pull = !sb_n[7];
		end else begin
			res.sda_pull = 1'b0;
		end
		res.busy   = (ph_n != PH_IDLE);
		res.done   = done_n;
		res.status = st_n;
		res.rdata  = rx_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q     <= DEV_ADDR_RST;
			qtr_q     <= QTR_BIT_RST;
			ack_lim_q <= ACK_WAIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DEV_ADDR: dev_q     <= cfg_wdata[6:0];
				REG_QTR_BIT:  qtr_q     <= cfg_wdata;
				REG_ACK_WAIT: ack_lim_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bc_q    <= '0;
			sb_q    <= '0;
			tc_q    <= '0;
			aw_q    <= '0;
			rd_q    <= 1'b0;
			sub_q   <= '0;
			wd_q    <= '0;
			st_q    <= ST_OK;
			rx_q    <= '0;
			bs_q    <= BS_ADDR;
		end else if (step_en) begin
			phase_q <= ph_n;
			bc_q    <= bc_n;
			sb_q    <= sb_n;
			tc_q    <= tc_n;
			aw_q    <= aw_n;
			rd_q    <= rd_n;
			sub_q   <= sub_n;
			wd_q    <= wd_n;
			st_q    <= st_n;
			rx_q    <= rx_n;
			bs_q    <= bs_n;
		end
	end

	a_done_from_stop: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && done_n |-> phase_q == PH_STOP_C)
		else $error("done raised outside final stop phase");

	a_bit_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= 4'd8)
		else $error("bit counter past one byte");

	a_ack_seen: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && phase_q == PH_ACK_WAIT && !item.sda |=> phase_q == PH_ACK_HOLD)
		else $error("ack not taken");

	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && ph_n == PH_IDLE |-> res.scl && !res.sda_pull)
		else $error("bus not released when idle");

endmodule

[rtl/i2cram_resq.sv]
// Result queue: holds finished result beats until the consumer pops them.
// Depends on i2cram_pkg; filled by i2cram_engine.
module i2cram_resq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_push,
	input  i2cram_pkg::result_t  res,
	output logic                 res_full,
	input  logic                 pop,
	output logic                 empty,
	output i2cram_pkg::result_t  head
);
	import i2cram_pkg::*;

	result_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 wr_en;
	logic                 rd_en;

	assign res_full = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign wr_en    = res_push && !res_full;
	assign rd_en    = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/i2c_register_access_master_unit.sv]
// Top level of the tick-driven I2C register access master.
// Instantiates i2cram_front, i2cram_engine and i2cram_resq; uses i2cram_pkg.
//
// Usage: every input beat is one bus-timing tick carrying the sampled SDA
// level; while idle, action starts a register write (1) or read (2).
// Input channel: a beat is taken when push is high and full is low.
// Result channel: the oldest result is on the result ports while empty is
// low and leaves when pop is high. Every input beat yields exactly one
// result beat with the SCL/SDA drive levels, busy, done, status and the
// last read byte.
// Path: a beat pushed into an empty block goes through the front queue, then
// one engine step moves it into the result queue and onto the result ports.
// Throughput: one beat per cycle while res_full does not hold the engine;
// two two-entry queues keep that rate while either side stalls briefly.
// Stall: if pop stays low the result queue fills, the engine holds, and
// full rises once the front queue holds two beats; nothing is dropped.
// Reset: arst_n empties both queues, puts the engine idle with status ok,
// and loads device address 39, 250 ticks per phase and an ACK wait of 400.
// Config writes (cfg_wr_en) take effect at once and belong to idle time.
module i2c_register_access_master_unit #(
	parameter int unsigned TICK_COUNT_BITS = i2cram_pkg::TICK_COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [7:0]  sub_address,
	input  logic [7:0]  write_data,
	input  logic        sda_in,
	output logic        empty,
	input  logic        pop,
	output logic        scl_out,
	output logic        sda_pull_low,
	output logic        busy_res,
	output logic        done_res,
	output logic [1:0]  status,
	output logic [7:0]  read_data
);
	import i2cram_pkg::*;

	item_t   item;
	logic    item_valid;
	logic    deq;
	logic    res_full;
	logic    res_push;
	result_t res;
	result_t head;

	i2cram_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.sub_address (sub_address),
		.write_data  (write_data),
		.sda_in      (sda_in),
		.deq         (deq),
		.item_valid  (item_valid),
		.item        (item)
	);

	i2cram_engine #(
		.TickBits (TICK_COUNT_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item       (item),
		.deq        (deq),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	i2cram_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	assign scl_out      = head.scl;
	assign sda_pull_low = head.sda_pull;
	assign busy_res     = head.busy;
	assign done_res     = head.done;
	assign status       = head.status;
	assign read_data    = head.rdata;

endmodule

[verif/i2cram_bus_checker.sv]
// Checker for the I2C register access master: tracks register writes, predicts
// one result beat per accepted tick and compares every popped beat field by field.
// Depends on i2cram_pkg for codes, reset values and the result_t layout.
module i2cram_bus_checker
	import i2cram_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  action,
	input  logic [7:0]  sub_address,
	input  logic [7:0]  write_data,
	input  logic        sda_in,
	input  logic        empty,
	input  logic        pop,
	input  logic        scl_out,
	input  logic        sda_pull_low,
	input  logic        busy_res,
	input  logic        done_res,
	input  logic [1:0]  status,
	input  logic [7:0]  read_data,
	output int          fails,
	output int          pending,
	output logic        bus_busy
);

	typedef enum logic [4:0] {
		BUS_IDLE, BUS_START_A, BUS_START_B, BUS_START_C, BUS_TX_LOW, BUS_TX_HIGH,
		BUS_ACK_LOW, BUS_ACK_WAIT, BUS_ACK_HOLD, BUS_RS_A, BUS_RS_B, BUS_RX_LOW,
		BUS_RX_HIGH, BUS_NACK_LOW, BUS_NACK_HIGH, BUS_STOP_A, BUS_STOP_B, BUS_STOP_C
	} bus_phase_e;

	typedef enum logic [1:0] {STG_ADDR, STG_SUB, STG_DATA, STG_READ} byte_stage_e;

	logic [6:0]  dev_addr_q;
	logic [15:0] qtr_ticks_q;
	logic [15:0] ack_limit_q;

	bus_phase_e  ph;
	byte_stage_e stage;
	logic [3:0]  bit_n;
	logic [7:0]  shreg;
	logic [15:0] tick_n;
	logic [15:0] ack_n;
	logic        rd_mode;
	logic [7:0]  sub_q;
	logic [7:0]  wdata_q;
	logic [1:0]  stat_q;
	logic [7:0]  rx_byte;

	result_t due_levels[$];
	result_t oldest;
	result_t fresh;
	int      err_n = 0;
	int      beat_n = 0;

	assign fails = err_n;

	task model_reset();
		dev_addr_q = DEV_ADDR_RST;
		qtr_ticks_q = QTR_BIT_RST;
		ack_limit_q = ACK_WAIT_RST;
		ph = BUS_IDLE;
		stage = STG_ADDR;
		bit_n = '0;
		shreg = '0;
		tick_n = '0;
		ack_n = '0;
		rd_mode = 1'b0;
		sub_q = '0;
		wdata_q = '0;
		stat_q = ST_OK;
		rx_byte = '0;
	endtask

	task enter(input bus_phase_e nx);
		ph = nx;
		tick_n = '0;
	endtask

	task load_tx(input logic [7:0] v);
		shreg = v;
		bit_n = '0;
		enter(BUS_TX_LOW);
	endtask

	task nack_stop();
		if (rd_mode) begin
			stat_q = ST_RD_NACK;
		end else if (stage == STG_DATA) begin
			stat_q = ST_WR_DAT_NACK;
		end else begin
			stat_q = ST_WR_ADR_NACK;
		end
		enter(BUS_STOP_A);
	endtask

	task next_byte();
		case (stage)
			STG_ADDR: begin
				stage = STG_SUB;
				load_tx(sub_q);
			end
			STG_SUB: begin
				if (rd_mode) begin
					stage = STG_READ;
					enter(BUS_RS_A);
				end else begin
					stage = STG_DATA;
					load_tx(wdata_q);
				end
			end
			STG_DATA: begin
				stat_q = ST_OK;
				enter(BUS_STOP_A);
			end
			default: begin
				shreg = '0;
				bit_n = '0;
				enter(BUS_RX_LOW);
			end
		endcase
	endtask

	// one tick of the bus engine; r gets the levels after the update
	task advance_bus(input logic [1:0] act, input logic [7:0] sa, input logic [7:0] wd,
			input logic sda, output result_t r);
		logic        fin;
		logic [15:0] lim;
		fin = 1'b0;
		lim = (qtr_ticks_q == 16'd0) ? 16'd0 : qtr_ticks_q - 16'd1;
		if (ph == BUS_IDLE) begin
			if (act == ACT_WRITE || act == ACT_READ) begin
				rd_mode = (act == ACT_READ);
				sub_q = sa;
				wdata_q = wd;
				stage = STG_ADDR;
				bit_n = '0;
				ack_n = '0;
				enter(BUS_START_A);
			end
		end else if (ph == BUS_ACK_WAIT) begin
			if (!sda) begin
				enter(BUS_ACK_HOLD);
			end else begin
				ack_n = ack_n + 16'd1;
				if (ack_n >= ack_limit_q)
					nack_stop();
			end
		end else if (tick_n < lim) begin
			tick_n = tick_n + 16'd1;
		end else begin
			case (ph)
				BUS_START_A: enter(BUS_START_B);
				BUS_START_B: enter(BUS_START_C);
				BUS_START_C: load_tx({dev_addr_q, stage == STG_READ});
				BUS_TX_LOW: enter(BUS_TX_HIGH);
				BUS_TX_HIGH: begin
					shreg = {shreg[6:0], 1'b0};
					bit_n = bit_n + 4'd1;
					if (bit_n >= 4'd8)
						enter(BUS_ACK_LOW);
					else
						enter(BUS_TX_LOW);
				end
				BUS_ACK_LOW: begin
					ack_n = '0;
					enter(BUS_ACK_WAIT);
				end
				BUS_ACK_HOLD: next_byte();
				BUS_RS_A: enter(BUS_RS_B);
				BUS_RS_B: enter(BUS_START_B);
				BUS_RX_LOW: enter(BUS_RX_HIGH);
				BUS_RX_HIGH: begin
					shreg = {shreg[6:0], sda};
					bit_n = bit_n + 4'd1;
					if (bit_n >= 4'd8) begin
						rx_byte = shreg;
						stat_q = ST_OK;
						enter(BUS_NACK_LOW);
					end else begin
						enter(BUS_RX_LOW);
					end
				end
				BUS_NACK_LOW: enter(BUS_NACK_HIGH);
				BUS_NACK_HIGH: enter(BUS_STOP_A);
				BUS_STOP_A: enter(BUS_STOP_B);
				BUS_STOP_B: enter(BUS_STOP_C);
				default: begin
					enter(BUS_IDLE);
					fin = 1'b1;
				end
			endcase
		end
		r.scl = !(ph inside {BUS_START_C, BUS_TX_LOW, BUS_ACK_LOW, BUS_RS_A,
			BUS_RX_LOW, BUS_NACK_LOW, BUS_STOP_A});
		if (ph inside {BUS_START_B, BUS_START_C, BUS_STOP_A, BUS_STOP_B})
			r.sda_pull = 1'b1;
		else if (ph inside {BUS_TX_LOW, BUS_TX_HIGH})
			r.sda_pull = !shreg[7];
		else
			r.sda_pull = 1'b0;
		r.busy = (ph != BUS_IDLE);
		r.done = fin;
		r.status = stat_q;
		r.rdata = rx_byte;
	endtask

	task flag_mismatch(input string what, input int got_v, input int want_v);
		err_n++;
		if (err_n <= 40)
			$display("mismatch at beat %0d, %s: got %0d, want %0d", beat_n, what, got_v, want_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_reset();
			due_levels.delete();
			pending <= 0;
			bus_busy <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (due_levels.size() == 0) begin
					flag_mismatch("beat with nothing expected", 1, 0);
				end else begin
					oldest = due_levels.pop_front();
					if (scl_out !== oldest.scl)
						flag_mismatch("scl_out", scl_out, oldest.scl);
					if (sda_pull_low !== oldest.sda_pull)
						flag_mismatch("sda_pull_low", sda_pull_low, oldest.sda_pull);
					if (busy_res !== oldest.busy)
						flag_mismatch("busy_res", busy_res, oldest.busy);
					if (done_res !== oldest.done)
						flag_mismatch("done_res", done_res, oldest.done);
					if (status !== oldest.status)
						flag_mismatch("status", status, oldest.status);
					if (read_data !== oldest.rdata)
						flag_mismatch("read_data", read_data, oldest.rdata);
				end
				beat_n++;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_DEV_ADDR: dev_addr_q = cfg_wdata[6:0];
					REG_QTR_BIT:  qtr_ticks_q = cfg_wdata;
					REG_ACK_WAIT: ack_limit_q = cfg_wdata;
					default: ;
				endcase
			end
			if (push && !full) begin
				advance_bus(action, sub_address, write_data, sda_in, fresh);
				due_levels.push_back(fresh);
			end
			pending <= due_levels.size();
			bus_busy <= (ph != BUS_IDLE);
		end
	end

endmodule

[verif/tb_top.sv]
// Testbench top for i2c_register_access_master_unit: clock, reset, register
// writes, tick stimulus with random idling, watchdog and the final verdict.
// Depends on i2cram_pkg and i2cram_bus_checker, which does all the checking.
module tb_top;
	import i2cram_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 60;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;
	logic        push;
	logic        full;
	logic [1:0]  action;
	logic [7:0]  sub_address;
	logic [7:0]  write_data;
	logic        sda_in;
	logic        empty;
	logic        pop;
	logic        scl_out;
	logic        sda_pull_low;
	logic        busy_res;
	logic        done_res;
	logic [1:0]  status;
	logic [7:0]  read_data;

	int   fails;
	int   pending;
	logic bus_busy;
	int   quiet = 0;
	logic calm;
	logic hold_off_req;
	logic hold_done;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	i2c_register_access_master_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.push(push), .full(full),
		.action(action), .sub_address(sub_address), .write_data(write_data), .sda_in(sda_in),
		.empty(empty), .pop(pop),
		.scl_out(scl_out), .sda_pull_low(sda_pull_low), .busy_res(busy_res),
		.done_res(done_res), .status(status), .read_data(read_data)
	);

	i2cram_bus_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.push(push), .full(full),
		.action(action), .sub_address(sub_address), .write_data(write_data), .sda_in(sda_in),
		.empty(empty), .pop(pop),
		.scl_out(scl_out), .sda_pull_low(sda_pull_low), .busy_res(busy_res),
		.done_res(done_res), .status(status), .read_data(read_data),
		.fails(fails), .pending(pending), .bus_busy(bus_busy)
	);

	function automatic logic line_level(input int pct);
		return ($urandom_range(0, 99) < pct);
	endfunction

	// one input beat, optionally after an idle burst; returns at acceptance
	task automatic offer(input logic [1:0] act, input logic [7:0] sa, input logic [7:0] wd,
			input logic sda);
		if (!calm && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		push <= 1'b1;
		action <= act;
		sub_address <= sa;
		write_data <= wd;
		sda_in <= sda;
		do @(posedge clk); while (full);
	endtask

	// stop sending until every beat is back; keep ticking while a transfer runs
	task automatic settle_bus(input int pct);
		logic again;
		again = 1'b1;
		while (again) begin
			push <= 1'b0;
			do @(posedge clk); while (pending != 0);
			again = bus_busy;
			if (again) begin
				repeat (16)
					offer(ACT_TICK, $urandom_range(0, 255), $urandom_range(0, 255),
						line_level(pct));
			end
		end
	endtask

	task automatic write_regs(input logic [6:0] dev, input logic [15:0] qtr,
			input logic [15:0] ackw);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_DEV_ADDR;
		cfg_wdata <= {9'd0, dev};
		@(posedge clk);
		cfg_index <= REG_QTR_BIT;
		cfg_wdata <= qtr;
		@(posedge clk);
		cfg_index <= REG_ACK_WAIT;
		cfg_wdata <= ackw;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_cmd(input logic [1:0] act, input logic [7:0] sa, input logic [7:0] wd,
			input int pct);
		offer(act, sa, wd, line_level(pct));
		settle_bus(pct);
	endtask

	task automatic random_traffic(input int n, input int pct);
		int         roll;
		logic [1:0] act;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 45)
				act = ACT_TICK;
			else if (roll < 70)
				act = ACT_WRITE;
			else if (roll < 92)
				act = ACT_READ;
			else
				act = ACT_UNUSED;
			offer(act, $urandom_range(0, 255), $urandom_range(0, 255), line_level(pct));
		end
		settle_bus(pct);
	endtask

	// receiver: random pop gaps, one long hold-off to back the block up
	initial begin
		pop <= 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req && !hold_done) begin
				pop <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_DEV_ADDR;
		cfg_wdata <= '0;
		push <= 1'b0;
		action <= ACT_TICK;
		sub_address <= '0;
		write_data <= '0;
		sda_in <= 1'b1;
		calm <= 1'b0;
		hold_off_req <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unknown register index must not disturb anything
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_UNUSED;
		cfg_wdata <= 16'hFFFF;
		@(posedge clk);
		cfg_wr_en <= 1'b0;

		// reset address and ack limit, shortest phase
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_QTR_BIT;
		cfg_wdata <= 16'd1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		run_cmd(ACT_WRITE, 8'h00, 8'hFF, 0);
		run_cmd(ACT_READ, 8'hFF, 8'h00, 60);

		write_regs(7'h7F, 16'd1, 16'd1);
		run_cmd(ACT_WRITE, 8'hFF, 8'h00, 100);
		run_cmd(ACT_READ, 8'h5A, 8'hC3, 0);
		run_cmd(ACT_UNUSED, 8'h12, 8'h34, 50);
		run_cmd(ACT_TICK, 8'hFF, 8'hFF, 100);

		// zero phase length and zero ack limit behave as one
		write_regs(7'h00, 16'd0, 16'd0);
		run_cmd(ACT_WRITE, 8'hA5, 8'h5A, 50);
		run_cmd(ACT_READ, 8'h3C, 8'h96, 50);
		run_cmd(ACT_READ, 8'hC3, 8'h69, 70);

		// longest ack limit, slave acks late
		write_regs(7'h27, 16'd1, 16'hFFFF);
		run_cmd(ACT_WRITE, 8'h11, 8'h22, 70);
		run_cmd(ACT_READ, 8'h80, 8'h01, 90);

		// longest phase, bus left idle
		write_regs(7'h27, 16'hFFFF, 16'd400);
		repeat (8)
			run_cmd(ACT_TICK, $urandom_range(0, 255), $urandom_range(0, 255), 50);

		write_regs(7'h7F, 16'd1, 16'd1);
		random_traffic(60, 50);
		write_regs(7'h00, 16'd2, 16'd3);
		random_traffic(60, 60);
		write_regs(7'h55, 16'd1, 16'd20);
		random_traffic(60, 85);
		write_regs(7'h2A, 16'd3, 16'd2);
		hold_off_req <= 1'b1;
		random_traffic(60, 30);
		write_regs(7'h13, 16'd0, 16'd4);
		random_traffic(60, 45);
		write_regs(7'h27, 16'd1, 16'd2);
		calm <= 1'b1;
		random_traffic(60, 50);

		repeat (8) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
